### design/rmfc_pkg.sv
`timescale 1ns / 1ps

package rmfc_pkg;

	localparam int unsigned CfgIndexWidth = 1;

	localparam logic [CfgIndexWidth-1:0] REG_MIN_FRAME_LENGTH = 1'd0;
	localparam logic [CfgIndexWidth-1:0] REG_MAX_FRAME_LENGTH = 1'd1;

	localparam logic [7:0] MIN_LENGTH_RESET = 8'd10;
	localparam logic [7:0] MAX_LENGTH_RESET = 8'd54;
	localparam logic [7:0] XOR_SEED         = 8'hFF;
	localparam logic [7:0] LENGTH_POS       = 8'd7;
	localparam logic [7:0] DEST_POS         = 8'd8;
	localparam logic [7:0] SOURCE_POS       = 8'd4;
	localparam logic [7:0] CONTROL_HI_POS   = 8'd5;
	localparam logic [7:0] CONTROL_LO_POS   = 8'd6;
	localparam logic [7:0] ID_BYTES         = 8'd4;
	localparam logic [7:0] SMALLEST_LENGTH  = 8'd9;
	localparam logic [7:0] INDEX_MAX        = 8'hFF;

	typedef enum logic [1:0] {
		STATUS_GOOD     = 2'd0,
		STATUS_SHORT    = 2'd1,
		STATUS_LONG     = 2'd2,
		STATUS_MISMATCH = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] network_id;
		logic [7:0]  source_node;
		logic [7:0]  dest_node;
		logic [3:0]  frame_kind;
		logic        routed;
		logic        ack_request;
		logic        low_power;
		logic        speed_modified;
		logic [1:0]  beam_control;
		logic [3:0]  sequence_number;
		logic [7:0]  frame_length;
	} result_t;

endpackage

### design/radio_mac_frame_checker.sv
`timescale 1ns / 1ps

// radio mac frame header checker
// item channel (item_valid/item_ready/item): one received byte per transaction,
// frame_start set on byte 0 of a frame; a start abandons any partial frame.
// result channel (result_valid/result_ready/result): at most one transaction per frame,
// either at the length byte when the length is out of range, or at the
// checksum byte (byte length-1) with good or mismatch status and the header.
// configuration: cfg_write_en, cfg_index, cfg_data write the min and max
// length registers; write them only while the block is idle.
// a byte is registered in the input register and its result is then
// registered in the result register.
// throughput: one byte per cycle unless a frame-ending byte stalls; the running
// xor, byte counter and header capture registers update once per byte in a single pass.
// reset: no frame active, registers back to min 10 and max 54, no result.
// stalls: a byte that causes no result moves on even while a result waits;
// a byte that ends a frame holds in the input register until the result
// register is free, and item_ready drops behind it.
module radio_mac_frame_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_ready,
	input  rmfc_pkg::item_t                       item,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output rmfc_pkg::result_t                     result,
	input  logic                                  cfg_write_en,
	input  logic [rmfc_pkg::CfgIndexWidth-1:0]    cfg_index,
	input  logic [7:0]                            cfg_data
);

	logic [7:0] min_len_q;
	logic [7:0] max_len_q;

	rmfc_pkg::item_t item_s1;
	logic            item_valid_s1;

	logic        active_q;
	logic [7:0]  index_q;
	logic [7:0]  xor_q;
	logic [31:0] id_q;
	logic [7:0]  source_q;
	logic [15:0] control_q;
	logic [7:0]  length_q;
	logic [7:0]  dest_q;

	rmfc_pkg::result_t result_q;
	logic              result_valid_q;

	// next-state values
	logic        active_n;
	logic [7:0]  index_n;
	logic [7:0]  xor_n;
	logic [31:0] id_n;
	logic [7:0]  source_n;
	logic [15:0] control_n;
	logic [7:0]  length_n;
	logic [7:0]  dest_n;
	logic        hit;
	logic        with_dest;
	rmfc_pkg::status_t status_n;
	rmfc_pkg::result_t result_n;
	logic        fire;
	logic        advance;
	logic [7:0]  b;
	logic        start;
	logic        act;

	always_comb begin
		b     = item_s1.data_byte;
		start = item_s1.frame_start;
		act   = active_q | start;

		index_n   = start ? '0 : index_q;
		xor_n     = start ? rmfc_pkg::XOR_SEED : xor_q;
		id_n      = start ? '0 : id_q;
		source_n  = start ? '0 : source_q;
		control_n = start ? '0 : control_q;
		length_n  = start ? '0 : length_q;
		dest_n    = start ? '0 : dest_q;
		active_n  = act;
		hit       = 1'b0;
		with_dest = 1'b0;
		status_n  = rmfc_pkg::STATUS_GOOD;

		if (act) begin
			if (index_n < rmfc_pkg::ID_BYTES) begin
				id_n = {id_n[23:0], b};
			end else if (index_n == rmfc_pkg::SOURCE_POS) begin
				source_n = b;
			end else if (index_n == rmfc_pkg::CONTROL_HI_POS) begin
				control_n[15:8] = b;
			end else if (index_n == rmfc_pkg::CONTROL_LO_POS) begin
				control_n[7:0] = b;
			end else if (index_n == rmfc_pkg::LENGTH_POS) begin
				length_n = b;
			end else if (index_n == rmfc_pkg::DEST_POS) begin
				dest_n = b;
			end

			if (index_n == rmfc_pkg::LENGTH_POS) begin
				// too short wins over too long when min exceeds max
				if (b < rmfc_pkg::SMALLEST_LENGTH || b < min_len_q) begin
					hit      = 1'b1;
					status_n = rmfc_pkg::STATUS_SHORT;
				end else if (b > max_len_q) begin
					hit      = 1'b1;
					status_n = rmfc_pkg::STATUS_LONG;
				end
			end

			if (!hit && index_n > rmfc_pkg::LENGTH_POS
					&& ({1'b0, index_n} + 9'd1) == {1'b0, length_n}) begin
				hit       = 1'b1;
				with_dest = 1'b1;
				status_n  = (xor_n == b) ? rmfc_pkg::STATUS_GOOD : rmfc_pkg::STATUS_MISMATCH;
			end

			if (!hit) begin
				xor_n = xor_n ^ b;
				if (index_n != rmfc_pkg::INDEX_MAX) begin
					index_n = index_n + 8'd1;
				end
			end
			active_n = !hit;
		end

		result_n.status          = status_n;
		result_n.network_id      = id_n;
		result_n.source_node     = source_n;
		result_n.dest_node       = with_dest ? dest_n : 8'd0;
		result_n.frame_kind      = control_n[11:8];
		result_n.routed          = control_n[15];
		result_n.ack_request     = control_n[14];
		result_n.low_power       = control_n[13];
		result_n.speed_modified  = control_n[12];
		result_n.beam_control    = control_n[6:5];
		result_n.sequence_number = control_n[3:0];
		result_n.frame_length    = length_n;
	end

	assign fire       = item_valid_s1 & hit;
	assign advance    = !hit || !result_valid_q || result_ready;
	assign item_ready = !item_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= rmfc_pkg::MIN_LENGTH_RESET;
			max_len_q <= rmfc_pkg::MAX_LENGTH_RESET;
		end else if (cfg_write_en) begin
			if (cfg_index == rmfc_pkg::REG_MIN_FRAME_LENGTH) begin
				min_len_q <= cfg_data;
			end
			if (cfg_index == rmfc_pkg::REG_MAX_FRAME_LENGTH) begin
				max_len_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item_ready) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			index_q   <= '0;
			xor_q     <= rmfc_pkg::XOR_SEED;
			id_q      <= '0;
			source_q  <= '0;
			control_q <= '0;
			length_q  <= '0;
			dest_q    <= '0;
		end else if (item_valid_s1 && advance) begin
			active_q  <= active_n;
			index_q   <= index_n;
			xor_q     <= xor_n;
			id_q      <= id_n;
			source_q  <= source_n;
			control_q <= control_n;
			length_q  <= length_n;
			dest_q    <= dest_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire && advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && advance) begin
			result_q <= result_n;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// a frame-ending byte never overwrites a result still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && result_valid_q && !result_ready) |-> !item_ready)
		else $error("result register overrun");

	// a delivered result always closes the frame
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && advance) |=> (!active_q && result_valid_q))
		else $error("frame still open after result");

	// a frame only closes through a result
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(active_q) |-> $past(fire && advance))
		else $error("frame closed without a result");

	// an accepted transaction lands in the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> item_valid_s1)
		else $error("accepted transaction lost");

endmodule
